[sv/sdtxf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sdtxf_pkg;

   // block geometry
   localparam int BLOCK_BYTES = 512;
   localparam int POS_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

   // payload widths
   localparam int INDEX_W = 6;
   localparam int ARG_W   = 32;
   localparam int BYTE_W  = 8;
   localparam int CRC16_W = 16;
   localparam int CRC7_W  = 8;
   localparam int ADDR_SHIFT = 9;

   // framing constants
   localparam logic [BYTE_W-1:0]  FILL_BYTE   = 8'hff;
   localparam logic [BYTE_W-1:0]  START_TOKEN = 8'hfe;
   localparam logic [BYTE_W-1:0]  CMD_PREFIX  = 8'h40;
   localparam logic [CRC7_W-1:0]  CRC7_POLY   = 8'h09;
   localparam logic [CRC16_W-1:0] CRC16_POLY  = 16'h1021;

   // item kind on the cmd field
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   // sequencer steps
   typedef logic [2:0] step_type;
   localparam step_type CMD_STEP_FILL0  = 3'd0;
   localparam step_type CMD_STEP_FILL1  = 3'd1;
   localparam step_type CMD_STEP_PREFIX = 3'd2;
   localparam step_type CMD_STEP_ARG3   = 3'd3;
   localparam step_type CMD_STEP_ARG2   = 3'd4;
   localparam step_type CMD_STEP_ARG1   = 3'd5;
   localparam step_type CMD_STEP_ARG0   = 3'd6;
   localparam step_type CMD_STEP_CRC    = 3'd7;
   localparam step_type DAT_STEP_TOKEN  = 3'd0;
   localparam step_type DAT_STEP_BYTE   = 3'd1;
   localparam step_type DAT_STEP_CRC_HI = 3'd2;
   localparam step_type DAT_STEP_CRC_LO = 3'd3;

   // one item held by the sequencer
   typedef struct packed {
      logic                 is_data;
      logic [INDEX_W-1:0]   cmd_index;
      logic [ARG_W-1:0]     argument;
      logic [BYTE_W-1:0]    data_byte;
      logic                 block_end;
      logic [CRC16_W-1:0]   block_crc;
   } item_type;

   // crc7 over one byte, msb first
   function automatic logic [CRC7_W-1:0] crc7_feed(input logic [CRC7_W-1:0] crc_i,
                                                  input logic [BYTE_W-1:0] b_i);
      logic [CRC7_W-1:0] c;
      logic [BYTE_W-1:0] b;
      c = crc_i;
      b = b_i;
      for (int i = 0; i < BYTE_W; i++) begin
         c = {c[CRC7_W-2:0], 1'b0};
         if (b[BYTE_W-1] ^ c[CRC7_W-1]) begin
            c = c ^ CRC7_POLY;
         end
         b = {b[BYTE_W-2:0], 1'b0};
      end
      return c;
   endfunction

   // crc16-ccitt over one byte
   function automatic logic [CRC16_W-1:0] crc16_feed(input logic [CRC16_W-1:0] crc_i,
                                                    input logic [BYTE_W-1:0] b_i);
      logic [CRC16_W-1:0] c;
      c = crc_i ^ {b_i, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC16_W-1]) begin
            c = {c[CRC16_W-2:0], 1'b0} ^ CRC16_POLY;
         end else begin
            c = {c[CRC16_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[sv/sdtxf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// request channel: one command frame or one data byte per item
interface sdtxf_req_if;
   logic                               valid;
   logic                               ready;
   logic                               cmd;
   logic [sdtxf_pkg::INDEX_W-1:0]      cmd_index;
   logic [sdtxf_pkg::ARG_W-1:0]        argument;
   logic                               block_address;
   logic [sdtxf_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, cmd, cmd_index, argument, block_address, data_byte,
                   input ready);
   modport sink   (input valid, cmd, cmd_index, argument, block_address, data_byte,
                   output ready);
endinterface

// response channel: one transmit byte per item
interface sdtxf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sdtxf_pkg::BYTE_W-1:0]       tx_byte;
   logic                               last;

   modport source (output valid, tx_byte, last, input ready);
   modport sink   (input valid, tx_byte, last, output ready);
endinterface
`default_nettype wire

[sv/sd_spi_tx_framer_top.sv]
// a taken item is held in the item register; its first byte reaches rsp through the response register
// one byte per cycle out of the single response register while rsp is ready; a command
//   is 8 bytes, a data byte 1 byte, 2 at block start and 3 at block end
// a new item loads in the same cycle the previous item's last byte moves out
// reset (synchronous): clears valids, block position and block crc, sets byte_addressed
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_tx_framer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,
   sdtxf_req_if.sink        req_ch,
   sdtxf_rsp_if.source      rsp_ch
);
   import sdtxf_pkg::*;

   logic                 byte_addressed_ff;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CRC16_W-1:0]   crc16_ff, crc16_in;
   item_type             item_ff, item_in;
   logic                 item_valid_ff, item_valid_in;
   step_type             step_ff, step_in;
   logic [CRC7_W-1:0]    crc7_ff, crc7_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 emit;
   logic                 seq_last;
   logic [BYTE_W-1:0]    seq_byte;
   logic [CRC16_W-1:0]   crc16_next;
   logic                 at_end;
   logic [ARG_W-1:0]     arg_scaled;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_addressed_ff <= 1'b1;
      end else if (csr_we) begin
         byte_addressed_ff <= csr_wdata;
      end
   end

   // handshake
   assign emit          = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !item_valid_ff || (emit && seq_last);
   assign accept        = req_ch.valid && req_ch.ready;

   // block state update and item capture
   assign crc16_next = crc16_feed(crc16_ff, req_ch.data_byte);
   assign at_end     = (pos_ff == POS_W'(BLOCK_BYTES - 1));
   assign arg_scaled = (req_ch.block_address && byte_addressed_ff)
                       ? (req_ch.argument << ADDR_SHIFT) : req_ch.argument;

   always_comb begin
      pos_in            = pos_ff;
      crc16_in          = crc16_ff;
      item_in           = item_ff;
      item_valid_in     = item_valid_ff;
      step_in           = step_ff;
      crc7_in           = crc7_ff;
      if (emit) begin
         step_in = step_ff + 3'd1;
         if (!item_ff.is_data) begin
            if (step_ff == CMD_STEP_FILL0) begin
               crc7_in = '0;
            end else if (step_ff != CMD_STEP_FILL1 && step_ff != CMD_STEP_CRC) begin
               crc7_in = crc7_feed(crc7_ff, seq_byte);
            end
         end
         if (seq_last) begin
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in       = 1'b1;
         item_in.is_data     = req_ch.cmd;
         item_in.cmd_index   = req_ch.cmd_index;
         item_in.argument    = arg_scaled;
         item_in.data_byte   = req_ch.data_byte;
         item_in.block_end   = at_end;
         item_in.block_crc   = crc16_next;
         crc7_in             = '0;
         if (req_ch.cmd == KIND_COMMAND) begin
            step_in  = CMD_STEP_FILL0;
            pos_in   = '0;
            crc16_in = '0;
         end else begin
            step_in = (pos_ff == '0) ? DAT_STEP_TOKEN : DAT_STEP_BYTE;
            if (at_end) begin
               pos_in   = '0;
               crc16_in = '0;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               crc16_in = crc16_next;
            end
         end
      end
   end

   // byte selection for the current step
   always_comb begin
      seq_byte = FILL_BYTE;
      seq_last = 1'b0;
      if (item_ff.is_data) begin
         case (step_ff)
            DAT_STEP_TOKEN: seq_byte = START_TOKEN;
            DAT_STEP_BYTE: begin
               seq_byte = item_ff.data_byte;
               seq_last = !item_ff.block_end;
            end
            DAT_STEP_CRC_HI: seq_byte = item_ff.block_crc[15:8];
            DAT_STEP_CRC_LO: begin
               seq_byte = item_ff.block_crc[7:0];
               seq_last = 1'b1;
            end
            default: seq_byte = FILL_BYTE;
         endcase
      end else begin
         case (step_ff)
            CMD_STEP_FILL0,
            CMD_STEP_FILL1:  seq_byte = FILL_BYTE;
            CMD_STEP_PREFIX: seq_byte = CMD_PREFIX | {2'b00, item_ff.cmd_index};
            CMD_STEP_ARG3:   seq_byte = item_ff.argument[31:24];
            CMD_STEP_ARG2:   seq_byte = item_ff.argument[23:16];
            CMD_STEP_ARG1:   seq_byte = item_ff.argument[15:8];
            CMD_STEP_ARG0:   seq_byte = item_ff.argument[7:0];
            CMD_STEP_CRC: begin
               seq_byte = {crc7_ff[6:0], 1'b1};
               seq_last = 1'b1;
            end
            default: seq_byte = FILL_BYTE;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = seq_byte;
         rsp_last_in  = seq_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         crc16_ff      <= '0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc16_ff      <= crc16_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      step_ff     <= step_in;
      crc7_ff     <= crc7_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.tx_byte = rsp_byte_ff;
   assign rsp_ch.last    = rsp_last_ff;

   // checks
   a_pos_in_block: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(BLOCK_BYTES - 1))
      else $error("block position past end of block");

   a_cmd_clears_block: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.cmd == KIND_COMMAND) |=> (pos_ff == '0) && (crc16_ff == '0))
      else $error("command did not clear block state");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> item_valid_ff)
      else $error("accepted item not held by sequencer");

   a_data_step_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && item_ff.is_data |-> step_ff <= DAT_STEP_CRC_LO)
      else $error("data item step out of range");

endmodule
`default_nettype wire

[test/sdtxf_frame_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module sdtxf_frame_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_wdata,
   sdtxf_req_if      req_ch,
   sdtxf_rsp_if      rsp_ch,
   output int        mismatch_count,
   output int        bytes_owed
);
   import sdtxf_pkg::*;

   // one byte expected on the wire
   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              last;
   } wire_byte_type;

   wire_byte_type      owed_q[$];
   logic               scale_blocks;
   int                 block_fill;
   logic [CRC16_W-1:0] block_crc;
   int                 rsp_seen;

   // crc7 kept in seven bits, message bits msb first
   function automatic logic [6:0] crc7_byte(input logic [6:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = b[i] ^ c[6];
         c  = {c[5:0], 1'b0};
         if (fb) begin
            c = c ^ CRC7_POLY[6:0];
         end
      end
      return c;
   endfunction

   // crc16-ccitt, one message bit at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = b[i] ^ c[15];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC16_POLY;
         end
      end
      return c;
   endfunction

   task automatic owe(input logic [7:0] b, input logic l);
      owed_q.push_back(wire_byte_type'{tx_byte: b, last: l});
   endtask

   // expected wire bytes for one accepted item
   task automatic frame_item();
      logic [ARG_W-1:0] arg;
      logic [6:0]       crc;
      logic [7:0]       hdr [5];
      logic [7:0]       db;
      if (req_ch.cmd == KIND_COMMAND) begin
         arg = req_ch.argument;
         if (req_ch.block_address && scale_blocks) begin
            arg = arg << ADDR_SHIFT;
         end
         hdr[0] = CMD_PREFIX | {2'b00, req_ch.cmd_index};
         hdr[1] = arg[31:24];
         hdr[2] = arg[23:16];
         hdr[3] = arg[15:8];
         hdr[4] = arg[7:0];
         owe(FILL_BYTE, 1'b0);
         owe(FILL_BYTE, 1'b0);
         crc = '0;
         for (int i = 0; i < 5; i++) begin
            crc = crc7_byte(crc, hdr[i]);
            owe(hdr[i], 1'b0);
         end
         owe({crc, 1'b1}, 1'b1);
         // a command drops any block in progress
         block_fill = 0;
         block_crc  = '0;
      end else begin
         db = req_ch.data_byte;
         if (block_fill == 0) begin
            owe(START_TOKEN, 1'b0);
         end
         block_crc = crc16_byte(block_crc, db);
         block_fill++;
         if (block_fill >= BLOCK_BYTES) begin
            owe(db, 1'b0);
            owe(block_crc[15:8], 1'b0);
            owe(block_crc[7:0], 1'b1);
            block_fill = 0;
            block_crc  = '0;
         end else begin
            owe(db, 1'b1);
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      bytes_owed     = 0;
      rsp_seen       = 0;
   end

   // results first, then the item taken on the same edge
   always @(posedge clock) begin
      wire_byte_type want;
      if (reset) begin
         owed_q.delete();
         scale_blocks = 1'b1;
         block_fill   = 0;
         block_crc    = '0;
      end else begin
         if (csr_we) begin
            scale_blocks = csr_wdata;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_q.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected byte %0d: got %02h last %0b", rsp_seen,
                           rsp_ch.tx_byte, rsp_ch.last);
               end
               mismatch_count++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_ch.tx_byte !== want.tx_byte || rsp_ch.last !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                              rsp_seen, want.tx_byte, want.last, rsp_ch.tx_byte,
                              rsp_ch.last);
                  end
                  mismatch_count++;
               end
            end
            rsp_seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            frame_item();
         end
      end
      bytes_owed = owed_q.size();
   end

endmodule
`default_nettype wire

[test/tb_sd_spi_tx_framer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_sd_spi_tx_framer_top;
   import sdtxf_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int LONG_HOLD    = 300;

   typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PATTERN} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;

   int mismatch_count;
   int bytes_owed;
   int cycle_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int rx_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   logic [7:0] rx_mask = 8'h5b;

   sdtxf_req_if req_ch ();
   sdtxf_rsp_if rsp_ch ();

   sd_spi_tx_framer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   sdtxf_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .bytes_owed     (bytes_owed)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: long hold on request, otherwise a changing stall pattern
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 120);
         rx_mask = 8'($urandom_range(1, 255));
      end
      rx_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN: begin
               rsp_ch.ready <= 1'b1;
            end
            RX_BUSY: begin
               rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            end
            RX_SPARSE: begin
               rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ch.ready <= rx_mask[0];
               rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
         endcase
      end
   end

   // offer one item, with a random gap between bursts
   task automatic send_req(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [ARG_W-1:0] arg, input logic blk,
                           input logic [BYTE_W-1:0] db);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= kind;
      req_ch.cmd_index     <= idx;
      req_ch.argument      <= arg;
      req_ch.block_address <= blk;
      req_ch.data_byte     <= db;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   // data byte with junk in the command fields, and the reverse
   task automatic send_command(input logic [INDEX_W-1:0] idx, input logic [ARG_W-1:0] arg,
                               input logic blk);
      send_req(KIND_COMMAND, idx, arg, blk, BYTE_W'($urandom()));
   endtask

   task automatic send_data(input logic [BYTE_W-1:0] db);
      send_req(KIND_DATA, INDEX_W'($urandom()), $urandom(), 1'($urandom()), db);
   endtask

   // stop offering and wait for every owed byte
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_byte_mode(input logic v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [ARG_W-1:0] random_argument();
      case ($urandom_range(0, 3))
         0: begin
            return $urandom_range(0, 4095);
         end
         1: begin
            return 32'hffff_ffff - $urandom_range(0, 255);
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // mostly command then a run of data bytes, some noise and headless data
   task automatic random_phase(input int n_items, input bit full_block);
      int stop_at;
      int run_len;
      int pick;
      bit need_full;
      stop_at   = items_sent + n_items + (full_block ? BLOCK_BYTES : 0);
      need_full = full_block;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (need_full || pick < 7) begin
            if ($urandom_range(0, 3) == 0) begin
               send_command(INDEX_W'($urandom()), random_argument(), 1'($urandom()));
            end else begin
               send_command(INDEX_W'($urandom_range(24, 25)), random_argument(),
                            1'($urandom()));
            end
            if (need_full) begin
               run_len   = BLOCK_BYTES + $urandom_range(0, 3);
               need_full = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               run_len = $urandom_range(25, 64);
            end else begin
               run_len = $urandom_range(0, 24);
            end
            repeat (run_len) send_data(BYTE_W'($urandom()));
         end else if (pick < 9) begin
            send_req(1'($urandom()), INDEX_W'($urandom()), $urandom(), 1'($urandom()),
                     BYTE_W'($urandom()));
         end else begin
            repeat ($urandom_range(1, 6)) send_data(BYTE_W'($urandom()));
         end
      end
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.cmd           = KIND_COMMAND;
      req_ch.cmd_index     = '0;
      req_ch.argument      = '0;
      req_ch.block_address = 1'b0;
      req_ch.data_byte     = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte addressing on: headless data, aborts, extremes, scaled wrap
      write_byte_mode(1'b1);
      send_data(8'ha5);
      send_data(8'h00);
      send_data(8'hff);
      send_command(6'd0, 32'h0000_0000, 1'b0);
      send_command(6'd63, 32'hffff_ffff, 1'b0);
      send_command(6'd17, 32'h0080_0001, 1'b1);
      send_command(6'd24, 32'hffff_ffff, 1'b1);
      send_data(8'h55);
      send_data(8'haa);
      send_command(6'd12, 32'h0000_0000, 1'b0);
      settle();

      // byte addressing off: block numbers go out unchanged
      write_byte_mode(1'b0);
      send_command(6'd24, 32'h0123_4567, 1'b1);
      send_command(6'd25, 32'hffff_ffff, 1'b1);
      send_data(8'h80);
      send_data(8'h01);
      settle();

      // a full block behind a long receiver hold
      write_byte_mode(1'b1);
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      random_phase(0, 1'b1);
      settle();

      // short mixed run with gaps
      write_byte_mode(1'b0);
      gaps_on = 1'b1;
      random_phase(12, 1'b0);
      settle();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && bytes_owed == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
